>>> sv/scsd_pkg.sv
`timescale 1ns / 1ps
package scsd_pkg;

  // line assembly
  localparam int LINE_MAX = 31;
  localparam int LC_W     = $clog2(LINE_MAX + 1);

  // servo slots
  localparam int SERVOS   = 4;
  localparam int CHANNELS = 4;
  localparam int CH_W     = 2;
  localparam int ITER_MAX = 3 * CHANNELS + 3;
  localparam int ITER_W   = $clog2(ITER_MAX + 1);

  // front to back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // angle limits
  localparam logic [7:0] ANGLE_MAX   = 8'd180;
  localparam logic [7:0] ANGLE_RESET = 8'd90;
  localparam logic [9:0] ACC_SAT     = 10'd999;

  // x/45 for x below 2**18 is (x * RECIP_45) >> RECIP_SHIFT
  localparam logic [18:0] RECIP_45    = 19'd372828;
  localparam int          RECIP_SHIFT = 24;

  // characters
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_VT    = 8'h0B;
  localparam logic [7:0] CHR_FF    = 8'h0C;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  // configuration register indexes
  localparam logic [1:0] REG_MIN_PULSE = 2'd0;
  localparam logic [1:0] REG_SPAN      = 2'd1;
  localparam logic [1:0] REG_GAP       = 2'd2;

  localparam logic [11:0] MIN_PULSE_RESET = 12'd1000;
  localparam logic [11:0] SPAN_RESET      = 12'd1000;
  localparam logic [15:0] GAP_RESET       = 16'd2000;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       pin_1;
    logic       pin_2;
    logic       pin_3;
    logic       pin_4;
    logic [7:0] angle_1;
    logic [7:0] angle_2;
    logic [7:0] angle_3;
    logic [7:0] angle_4;
    logic       line_accepted;
  } out_t;

  typedef logic [SERVOS-1:0][7:0] angles_t;

  // one classified item travelling from the parser to the slot engine
  typedef struct packed {
    logic    is_tick;
    angles_t angles;
    logic    accepted;
  } entry_t;

  typedef struct packed {
    logic [11:0] min_pulse;
    logic [11:0] span;
    logic [15:0] gap;
  } cfg_t;

endpackage

>>> sv/scsd_parse.sv
`timescale 1ns / 1ps
module scsd_parse import scsd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   accept,
  input  in_t    item,
  output entry_t entry
);

  typedef enum logic [2:0] {
    PH_SKIP  = 3'b001,
    PH_SIGN  = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  logic [LC_W-1:0] line_cnt_r, line_cnt_nxt;
  logic [1:0]      field_idx_r, field_idx_nxt;
  phase_t          phase_r, phase_nxt;
  logic            neg_r, neg_nxt;
  logic [9:0]      acc_r, acc_nxt;
  logic [2:0][7:0] capt_r, capt_nxt;
  logic            failed_r, failed_nxt;
  logic            ended_r, ended_nxt;
  angles_t         angle_r, angle_nxt;

  logic        is_digit;
  logic        is_blank;
  logic [13:0] acc_grow;
  logic [7:0]  clamp_val;
  logic        line_ok;
  logic        accepted;
  logic [7:0]  c;

  assign c        = item.rx_byte;
  assign is_digit = c inside {[CHR_ZERO:CHR_NINE]};
  assign is_blank = c inside {CHR_SPACE, CHR_TAB, CHR_VT, CHR_FF};
  assign acc_grow = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {10'd0, c[3:0]};
  assign line_ok  = !failed_r && (field_idx_r == 2'd3) && (phase_r == PH_DIGIT);

  always_comb begin
    if (neg_r) begin
      clamp_val = 8'd0;
    end else if (acc_r > {2'd0, ANGLE_MAX}) begin
      clamp_val = ANGLE_MAX;
    end else begin
      clamp_val = acc_r[7:0];
    end
  end

  always_comb begin
    line_cnt_nxt  = line_cnt_r;
    field_idx_nxt = field_idx_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    capt_nxt      = capt_r;
    failed_nxt    = failed_r;
    ended_nxt     = ended_r;
    angle_nxt     = angle_r;
    accepted      = 1'b0;
    if (accept && !item.action) begin
      if (c == CHR_LF || c == CHR_CR) begin
        accepted = line_ok;
        if (line_ok) begin
          angle_nxt[0] = capt_r[0];
          angle_nxt[1] = capt_r[1];
          angle_nxt[2] = capt_r[2];
          angle_nxt[3] = clamp_val;
        end
        line_cnt_nxt  = '0;
        field_idx_nxt = '0;
        phase_nxt     = PH_SKIP;
        neg_nxt       = 1'b0;
        acc_nxt       = '0;
        failed_nxt    = 1'b0;
        ended_nxt     = 1'b0;
      end else if (line_cnt_r < LC_W'(LINE_MAX)) begin
        line_cnt_nxt = line_cnt_r + 1'b1;
        if (!(ended_r || failed_r)) begin
          if (c == CHR_NUL) begin
            ended_nxt = 1'b1;
          end else if (phase_r == PH_DIGIT) begin
            if (is_digit) begin
              acc_nxt = (acc_grow > {4'd0, ACC_SAT}) ? ACC_SAT : acc_grow[9:0];
            end else if (field_idx_r == 2'd3) begin
              ended_nxt = 1'b1;
            end else if (c == CHR_COMMA) begin
              capt_nxt[field_idx_r] = clamp_val;
              field_idx_nxt         = field_idx_r + 1'b1;
              phase_nxt             = PH_SKIP;
              acc_nxt               = '0;
              neg_nxt               = 1'b0;
            end else begin
              failed_nxt = 1'b1;
            end
          end else if (is_digit) begin
            phase_nxt = PH_DIGIT;
            acc_nxt   = {6'd0, c[3:0]};
          end else if (phase_r == PH_SKIP && is_blank) begin
            phase_nxt = PH_SKIP;
          end else if (phase_r == PH_SKIP && (c == CHR_PLUS || c == CHR_MINUS)) begin
            phase_nxt = PH_SIGN;
            neg_nxt   = (c == CHR_MINUS);
          end else begin
            failed_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r  <= '0;
      field_idx_r <= '0;
      phase_r     <= PH_SKIP;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      capt_r      <= '0;
      failed_r    <= 1'b0;
      ended_r     <= 1'b0;
      angle_r     <= {SERVOS{ANGLE_RESET}};
    end else begin
      line_cnt_r  <= line_cnt_nxt;
      field_idx_r <= field_idx_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      capt_r      <= capt_nxt;
      failed_r    <= failed_nxt;
      ended_r     <= ended_nxt;
      angle_r     <= angle_nxt;
    end
  end

  assign entry.is_tick  = item.action;
  assign entry.angles   = angle_nxt;
  assign entry.accepted = accepted;

`ifndef NO_ASSERTIONS
  a_angles_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (angle_r[0] <= ANGLE_MAX) && (angle_r[1] <= ANGLE_MAX) &&
    (angle_r[2] <= ANGLE_MAX) && (angle_r[3] <= ANGLE_MAX))
    else $error("commanded angle above limit");
`endif

endmodule

>>> sv/scsd_queue.sv
`timescale 1ns / 1ps
module scsd_queue import scsd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  entry_t          mem [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full       = (cnt_r == QC_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= QC_W'(QUEUE_DEPTH)) &&
    ((QA_W'(wr_ptr_r - rd_ptr_r) == cnt_r[QA_W-1:0])))
    else $error("queue fill and pointers disagree");
`endif

endmodule

>>> sv/scsd_slot.sv
`timescale 1ns / 1ps
module scsd_slot import scsd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   head_valid,
  input  entry_t head,
  output logic   head_pop,
  output logic   empty,
  input  logic   pop,
  output out_t   out_data
);

  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_MUL = 3'b010,
    ST_ADD = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic              high_r, high_nxt;
  logic [15:0]       count_r, count_nxt;
  logic [12:0]       width_r, width_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [19:0]       prod_r, prod_nxt;
  logic [36:0]       quo_r, quo_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic              out_ready;
  logic              step;
  logic              done;
  logic [CH_W-1:0]   ch_adv;
  logic [ITER_W-1:0] iter_inc;
  logic [3:0]        pin;

  assign out_ready = !out_valid_r || pop;
  assign step      = head_valid && out_ready;
  assign ch_adv    = (ch_r == CH_W'(CHANNELS - 1)) ? '0 : ch_r + 1'b1;
  assign iter_inc  = iter_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    high_nxt  = high_r;
    count_nxt = count_r;
    width_nxt = width_r;
    ch_nxt    = ch_r;
    iter_nxt  = iter_r;
    prod_nxt  = prod_r;
    quo_nxt   = quo_r;
    done      = 1'b0;
    if (step) begin
      case (state_r)
        ST_RUN: begin
          if (!head.is_tick) begin
            done = 1'b1;
          end else if (high_r) begin
            if (count_r < {3'd0, width_r}) begin
              count_nxt = count_r + 1'b1;
              done      = 1'b1;
            end else begin
              // pulse over: start the gap, or skip to the next channel
              high_nxt  = 1'b0;
              count_nxt = cfg.gap;
              if (cfg.gap == '0) begin
                ch_nxt = ch_adv;
              end
              iter_nxt = iter_inc;
              done     = (iter_inc == ITER_W'(ITER_MAX));
            end
          end else if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
            if (count_r == 16'd1) begin
              ch_nxt = ch_adv;
            end
            done = 1'b1;
          end else begin
            prod_nxt  = {12'd0, head.angles[ch_r]} * {8'd0, cfg.span};
            state_nxt = ST_MUL;
          end
        end
        ST_MUL: begin
          quo_nxt   = {19'd0, prod_r[19:2]} * {18'd0, RECIP_45};
          state_nxt = ST_ADD;
        end
        ST_ADD: begin
          width_nxt = {1'b0, cfg.min_pulse} + {1'b0, quo_r[RECIP_SHIFT+11:RECIP_SHIFT]};
          high_nxt  = 1'b1;
          count_nxt = '0;
          iter_nxt  = iter_inc;
          done      = (iter_inc == ITER_W'(ITER_MAX));
          state_nxt = ST_RUN;
        end
        default: begin
          state_nxt = ST_RUN;
        end
      endcase
      if (done) begin
        iter_nxt = '0;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      pin[j] = high_nxt && (count_nxt != '0) && (ch_nxt == CH_W'(j));
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (done) begin
      out_valid_nxt         = 1'b1;
      out_nxt.pin_1         = pin[0];
      out_nxt.pin_2         = pin[1];
      out_nxt.pin_3         = pin[2];
      out_nxt.pin_4         = pin[3];
      out_nxt.angle_1       = head.angles[0];
      out_nxt.angle_2       = head.angles[1];
      out_nxt.angle_3       = head.angles[2];
      out_nxt.angle_4       = head.angles[3];
      out_nxt.line_accepted = head.accepted;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      high_r      <= 1'b0;
      count_r     <= '0;
      width_r     <= '0;
      ch_r        <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      high_r      <= high_nxt;
      count_r     <= count_nxt;
      width_r     <= width_nxt;
      ch_r        <= ch_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    quo_r  <= quo_nxt;
    out_r  <= out_nxt;
  end

  assign head_pop = done;
  assign empty    = !out_valid_r;
  assign out_data = out_r;

`ifndef NO_ASSERTIONS
  a_calc_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> (head_valid && head.is_tick))
    else $error("width calculation without a tick at the head");

  a_iter_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    iter_r < ITER_W'(ITER_MAX))
    else $error("slot iteration count out of range");

  a_busy_without_head: assert property (@(posedge clk) disable iff (!rst_n)
    (iter_r != '0) |-> head_valid)
    else $error("tick in progress without a queued item");
`endif

endmodule

>>> sv/serial_commanded_four_servo_driver.sv
`timescale 1ns / 1ps
// four-channel rc servo driver commanded by text lines. bytes (action 0) build
// a line of up to 31 characters that ends at cr or lf; it is read as four
// comma-separated signed decimals, and only a line that gives all four
// updates the angles, each saturated then clamped to 0..180. ticks (action 1)
// step the pin sequencer: each channel in turn is high for
// min_pulse_us + angle*span_us/180 ticks, then low for gap_us ticks. every
// transfer in gives exactly one transfer out, in order, through a registered
// output. bytes, and ticks that only move a counter, stream through the slot
// engine at one per cycle while the result channel keeps popping. a tick that
// ends a pulse goes on to the gap or, with no gap, to the next slot, and each
// new slot it opens needs the width (angle*span multiply, reciprocal multiply
// for /180, add of min_pulse); with every slot empty a tick runs 15 steps. a
// four-entry queue between the line parser and the slot engine keeps input
// transfers flowing while the engine is busy.
module serial_commanded_four_servo_driver import scsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  in_t         in_data,
  // result channel
  output logic        empty,
  input  logic        pop,
  output out_t        out_data,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  cfg_t   cfg_r, cfg_nxt;
  logic   in_xfer;
  entry_t entry;
  entry_t head;
  logic   head_valid;
  logic   head_pop;

  // register file: index past the list is ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_MIN_PULSE: cfg_nxt.min_pulse = cfg_wdata[11:0];
        REG_SPAN:      cfg_nxt.span      = cfg_wdata[11:0];
        REG_GAP:       cfg_nxt.gap       = cfg_wdata;
        default:       cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_pulse <= MIN_PULSE_RESET;
      cfg_r.span      <= SPAN_RESET;
      cfg_r.gap       <= GAP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // an input transfer is parsed at once and always yields one queue entry
  assign in_xfer = push && !full;

  scsd_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_xfer),
    .item   (in_data),
    .entry  (entry)
  );

  scsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_xfer),
    .push_data  (entry),
    .full       (full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // slot engine owns the pin state and the output register
  scsd_slot u_slot (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data)
  );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import scsd_pkg::*;

  // item kinds on the input channel
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // run ends here no matter what, far above the slowest correct run
  localparam int CYCLE_LIMIT = 600000;

  // parser position inside one number
  typedef enum logic [1:0] {PH_BLANK, PH_SIGN, PH_DIGITS} field_phase_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        push      = 1'b0;
  logic        full;
  in_t         in_data   = '0;
  logic        empty;
  logic        pop       = 1'b0;
  out_t        out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_idx   = REG_MIN_PULSE;
  logic [15:0] cfg_wdata = '0;

  serial_commanded_four_servo_driver u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // bytes and ticks waiting to be sent, and servo outputs still to come back
  in_t  items_to_send[$];
  out_t servo_outputs_due[$];
  int   mismatch_count = 0;
  int   cycle_count    = 0;

  // ---------------------------------------------------------------------
  // predicted block state
  // ---------------------------------------------------------------------
  // timing registers as last written
  logic [11:0]  t_min, t_span;
  logic [15:0]  t_gap;
  // line parser
  int           line_len;
  int           fld_idx;
  field_phase_t fld_phase;
  logic         minus_seen;
  int           acc;
  logic [7:0]   held_val[3];
  logic         bad_line;
  logic         text_done;
  // servo sequencer
  logic [7:0]   angle_now[SERVOS];
  int           slot_ch;
  logic         slot_on;
  int           slot_cnt;
  int           slot_len;

  task automatic reset_predictor();
    t_min      = MIN_PULSE_RESET;
    t_span     = SPAN_RESET;
    t_gap      = GAP_RESET;
    line_len   = 0;
    fld_idx    = 0;
    fld_phase  = PH_BLANK;
    minus_seen = 1'b0;
    acc        = 0;
    bad_line   = 1'b0;
    text_done  = 1'b0;
    for (int i = 0; i < 3; i++) held_val[i] = '0;
    for (int i = 0; i < SERVOS; i++) angle_now[i] = ANGLE_RESET;
    slot_ch  = 0;
    slot_on  = 1'b0;
    slot_cnt = 0;
    slot_len = 0;
  endtask

  // value of the number being read, negatives to zero, big ones to 180
  function automatic logic [7:0] clamped_angle();
    if (minus_seen) return 8'd0;
    return (acc > ANGLE_MAX) ? ANGLE_MAX : 8'(acc);
  endfunction

  // one character of a line, read as %d-style numbers on the fly
  function automatic void parse_char(logic [7:0] c);
    logic digit;
    digit = (c >= CHR_ZERO) && (c <= CHR_NINE);
    if (text_done || bad_line) return;
    if (c == CHR_NUL) begin
      text_done = 1'b1;
      return;
    end
    if (fld_phase == PH_DIGITS) begin
      if (digit) begin
        acc = acc * 10 + (c - CHR_ZERO);
        if (acc > ACC_SAT) acc = ACC_SAT;
      end else if (fld_idx >= 3) begin
        // fourth number done, the rest is trailing text
        text_done = 1'b1;
      end else if (c == CHR_COMMA) begin
        held_val[fld_idx] = clamped_angle();
        fld_idx++;
        fld_phase  = PH_BLANK;
        acc        = 0;
        minus_seen = 1'b0;
      end else begin
        bad_line = 1'b1;
      end
      return;
    end
    if (digit) begin
      fld_phase = PH_DIGITS;
      acc       = c - CHR_ZERO;
    end else if (fld_phase == PH_BLANK && (c == CHR_SPACE || c == CHR_TAB ||
                                           c == CHR_VT || c == CHR_FF)) begin
      // leading blank, skipped
    end else if (fld_phase == PH_BLANK && (c == CHR_PLUS || c == CHR_MINUS)) begin
      fld_phase  = PH_SIGN;
      minus_seen = (c == CHR_MINUS);
    end else begin
      bad_line = 1'b1;
    end
  endfunction

  // cr or lf: commit the four angles only for a complete line
  function automatic logic close_line();
    logic ok;
    ok = !bad_line && fld_idx == 3 && fld_phase == PH_DIGITS;
    if (ok) begin
      angle_now[0] = held_val[0];
      angle_now[1] = held_val[1];
      angle_now[2] = held_val[2];
      angle_now[3] = clamped_angle();
    end
    line_len   = 0;
    fld_idx    = 0;
    fld_phase  = PH_BLANK;
    minus_seen = 1'b0;
    acc        = 0;
    bad_line   = 1'b0;
    text_done  = 1'b0;
    return ok;
  endfunction

  function automatic void next_slot();
    slot_ch  = (slot_ch + 1) % CHANNELS;
    slot_on  = 1'b0;
    slot_cnt = 0;
  endfunction

  // one microsecond: pulse counts up, gap counts down, empty slots are skipped
  function automatic void advance_servo_tick();
    for (int n = 0; n < ITER_MAX; n++) begin
      if (slot_on) begin
        if (slot_cnt < slot_len) begin
          slot_cnt++;
          return;
        end
        slot_on  = 1'b0;
        slot_cnt = t_gap;
        if (slot_cnt == 0) next_slot();
        continue;
      end
      if (slot_cnt != 0) begin
        slot_cnt--;
        if (slot_cnt == 0) next_slot();
        return;
      end
      slot_len = t_min + (int'(angle_now[slot_ch % SERVOS]) * int'(t_span)) / 180;
      slot_on  = 1'b1;
      slot_cnt = 0;
    end
  endfunction

  // expected servo output for one accepted transfer
  function automatic void predict_servo_outputs(in_t item);
    out_t res;
    logic accepted;
    accepted = 1'b0;
    if (item.action == ACT_TICK) begin
      advance_servo_tick();
    end else if (item.rx_byte == CHR_LF || item.rx_byte == CHR_CR) begin
      accepted = close_line();
    end else if (line_len < LINE_MAX) begin
      line_len++;
      parse_char(item.rx_byte);
    end
    res.pin_1         = slot_on && slot_cnt != 0 && slot_ch == 0;
    res.pin_2         = slot_on && slot_cnt != 0 && slot_ch == 1;
    res.pin_3         = slot_on && slot_cnt != 0 && slot_ch == 2;
    res.pin_4         = slot_on && slot_cnt != 0 && slot_ch == 3;
    res.angle_1       = angle_now[0];
    res.angle_2       = angle_now[1];
    res.angle_3       = angle_now[2];
    res.angle_4       = angle_now[3];
    res.line_accepted = accepted;
    servo_outputs_due.push_back(res);
  endfunction

  // ---------------------------------------------------------------------
  // clock, reset, watchdog
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // sender: bursts of transfers with random gaps between them
  // ---------------------------------------------------------------------
  logic sender_gaps     = 1'b0;
  logic receiver_stalls = 1'b0;
  int   burst_left      = 1;
  int   gap_left        = 0;
  logic next_push;
  in_t  next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      next_push = push;
      next_item = in_data;
      // transfer happens at this edge
      if (push && !full) begin
        predict_servo_outputs(in_data);
        next_push = 1'b0;
      end
      // load the next item right away unless a gap is running
      if (!next_push && items_to_send.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          next_item = items_to_send.pop_front();
          next_push = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = !sender_gaps ? 0 :
                         ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      push    <= next_push;
      in_data <= next_item;
    end
  end

  // ---------------------------------------------------------------------
  // receiver: pop follows a rotating stall pattern, reloaded now and then
  // ---------------------------------------------------------------------
  logic [15:0] stall_pattern = 16'hB5A7;
  int          stall_pos     = 0;

  function automatic void compare_field(string name, logic [7:0] expv, logic [7:0] actv);
    if (actv !== expv) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
      mismatch_count++;
    end
  endfunction

  function automatic void check_servo_outputs(out_t got);
    out_t want;
    if (servo_outputs_due.size() == 0) begin
      $error("result transfer with no expected output pending");
      mismatch_count++;
      return;
    end
    want = servo_outputs_due.pop_front();
    compare_field("pin_1", 8'(want.pin_1), 8'(got.pin_1));
    compare_field("pin_2", 8'(want.pin_2), 8'(got.pin_2));
    compare_field("pin_3", 8'(want.pin_3), 8'(got.pin_3));
    compare_field("pin_4", 8'(want.pin_4), 8'(got.pin_4));
    compare_field("angle_1", want.angle_1, got.angle_1);
    compare_field("angle_2", want.angle_2, got.angle_2);
    compare_field("angle_3", want.angle_3, got.angle_3);
    compare_field("angle_4", want.angle_4, got.angle_4);
    compare_field("line_accepted", 8'(want.line_accepted), 8'(got.line_accepted));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_servo_outputs(out_data);
      if (!receiver_stalls) begin
        pop <= 1'b1;
      end else begin
        pop <= stall_pattern[stall_pos];
        if (stall_pos == 15) begin
          stall_pos = 0;
          // new pattern sometimes; bit 0 set so it never stalls for good
          if ($urandom_range(0, 3) == 0) stall_pattern = 16'($urandom) | 16'h0001;
        end else begin
          stall_pos++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  logic [7:0] line_buf[$];
  int         items_queued;

  task automatic queue_item(logic act, logic [7:0] b);
    in_t it;
    it.action  = act;
    // the byte field of a tick is don't-care, so it carries random bits
    it.rx_byte = (act == ACT_TICK) ? 8'($urandom) : b;
    items_to_send.push_back(it);
    items_queued++;
  endtask

  task automatic queue_ticks(int n);
    repeat (n) queue_item(ACT_TICK, 8'h00);
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_item(ACT_BYTE, s[i]);
  endtask

  // four numbers with random blanks, signs, sizes and trailing text
  task automatic compose_command_line();
    string s;
    int    v;
    line_buf.delete();
    for (int f = 0; f < 4; f++) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 3))
            0:       line_buf.push_back(CHR_SPACE);
            1:       line_buf.push_back(CHR_TAB);
            2:       line_buf.push_back(CHR_VT);
            default: line_buf.push_back(CHR_FF);
          endcase
        end
      end
      case ($urandom_range(0, 5))
        0:       line_buf.push_back(CHR_PLUS);
        1:       line_buf.push_back(CHR_MINUS);
        default: ;
      endcase
      v = ($urandom_range(0, 9) == 0) ? $urandom_range(181, 99999) : $urandom_range(0, 180);
      if ($urandom_range(0, 7) == 0) line_buf.push_back(CHR_ZERO);
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
      if (f < 3) line_buf.push_back(CHR_COMMA);
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(33, 126)));
    end
  endtask

  // break a good line: wrong byte, dropped byte, zero byte, padding, cut
  task automatic corrupt_line();
    logic [7:0] tmp[$];
    int         pos;
    int         how;
    pos = $urandom_range(0, line_buf.size() - 1);
    how = $urandom_range(0, 4);
    tmp.delete();
    // padding can push the real content past the line length limit
    if (how == 3) repeat ($urandom_range(20, 40)) tmp.push_back(CHR_SPACE);
    for (int i = 0; i < line_buf.size(); i++) begin
      if (i == pos && how == 4) break;
      if (i == pos && how == 0) begin
        tmp.push_back(8'($urandom));
      end else if (i == pos && how == 1) begin
        // byte dropped
      end else if (i == pos && how == 2) begin
        tmp.push_back(CHR_NUL);
        tmp.push_back(line_buf[i]);
      end else begin
        tmp.push_back(line_buf[i]);
      end
    end
    line_buf = tmp;
  endtask

  task automatic compose_noise();
    line_buf.delete();
    repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom));
  endtask

  // send the line with ticks mixed in, then its terminator
  task automatic emit_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      if ($urandom_range(0, 2) == 0) queue_ticks($urandom_range(1, 4));
      queue_item(ACT_BYTE, line_buf[i]);
    end
    case ($urandom_range(0, 4))
      0:       queue_item(ACT_BYTE, CHR_CR);
      1: begin
        queue_item(ACT_BYTE, CHR_CR);
        queue_item(ACT_BYTE, CHR_LF);
      end
      default: queue_item(ACT_BYTE, CHR_LF);
    endcase
  endtask

  // block is idle once nothing is queued, in flight or owed
  task automatic wait_idle();
    while (items_to_send.size() != 0 || push || servo_outputs_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MIN_PULSE: t_min  = val[11:0];
      REG_SPAN:      t_span = val[11:0];
      REG_GAP:       t_gap  = val;
      default: ;
    endcase
  endtask

  // one setting of the timing registers, then a batch of random traffic
  task automatic run_phase(int min_pulse, int span, int gap, int target);
    int pick;
    wait_idle();
    write_reg(REG_MIN_PULSE, 16'(min_pulse));
    write_reg(REG_SPAN, 16'(span));
    write_reg(REG_GAP, 16'(gap));
    @(posedge clk);
    cfg_we <= 1'b0;
    sender_gaps     = ($urandom_range(0, 3) != 0);
    receiver_stalls = ($urandom_range(0, 3) != 0);
    items_queued    = 0;
    while (items_queued < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        compose_command_line();
        emit_line();
      end else if (pick < 75) begin
        compose_command_line();
        corrupt_line();
        emit_line();
      end else if (pick < 85) begin
        compose_noise();
        emit_line();
      end else begin
        queue_ticks($urandom_range(5, 40));
      end
    end
  endtask

  initial begin
    reset_predictor();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset timing, saturation, negative, plus sign, trailing text,
    // cr ending, an all-ones byte, a zero byte cutting a line short
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    queue_ticks(2);
    queue_text("9,-1,9999,+5z");
    queue_item(ACT_BYTE, CHR_CR);
    queue_item(ACT_BYTE, 8'hFF);
    queue_item(ACT_BYTE, CHR_LF);
    queue_text("1, 2");
    queue_item(ACT_BYTE, CHR_NUL);
    queue_item(ACT_BYTE, CHR_LF);
    queue_ticks(2);

    // random traffic over several timing settings, extremes among them
    run_phase(3, 20, 4, 170);
    run_phase(0, 0, 0, 120);             // every slot empty
    run_phase(0, 360, 0, 170);           // angle zero gives an empty pulse
    run_phase(4095, 4095, 65535, 60);    // widest pulse and gap
    run_phase(1, 9, 2, 170);
    repeat (4) begin
      run_phase($urandom_range(0, 12), $urandom_range(0, 200), $urandom_range(0, 12), 170);
    end

    wait_idle();
    // room for any stray output
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && servo_outputs_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
